FILE: sv/layer_alpha_compositor_defines.svh
// ---------------------------------------------------------------------------
// Layer alpha compositor assertion macros
// Shared property shorthands for the compositor checker.
// ---------------------------------------------------------------------------
`ifndef LAYER_ALPHA_COMPOSITOR_DEFINES_SVH
`define LAYER_ALPHA_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define LAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define LAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define LAC_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/lac_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Layer alpha compositor package
// Widths, format codes and the controller/datapath command and status types.
// ---------------------------------------------------------------------------
package lac_pkg;

   localparam int LAC_PIX_W  = 8;
   localparam int LAC_PROD_W = 16;
   localparam int LAC_NUM_W  = 24;
   localparam int LAC_DEN_W  = 16;
   localparam int LAC_FMT_W  = 2;
   localparam int LAC_NCH    = 3;

   localparam logic [LAC_FMT_W-1:0] LAC_FMT_GRAY  = 2'd0;
   localparam logic [LAC_FMT_W-1:0] LAC_FMT_RGBA  = 2'd1;
   localparam logic [LAC_FMT_W-1:0] LAC_FMT_COPY  = 2'd2;
   localparam logic [LAC_FMT_W-1:0] LAC_FMT_RSVD  = 2'd3;

   localparam logic [LAC_PIX_W-1:0] LAC_OPAQUE = 8'd255;

   typedef struct packed {
      logic accept;
      logic mul;
      logic div_load;
      logic div_step;
      logic write_back;
      logic emit;
   } lac_cmd_type;

   typedef struct packed {
      logic skip_merge;
      logic req_last;
      logic item_last;
   } lac_stat_type;

endpackage

FILE: sv/lac_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Layer alpha compositor request channel
// Valid/ready channel carrying one layer pixel per request.
// ---------------------------------------------------------------------------
interface lac_req_if import lac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [LAC_PIX_W-1:0] channel_zero;
   logic [LAC_PIX_W-1:0] channel_one;
   logic [LAC_PIX_W-1:0] channel_two;
   logic [LAC_PIX_W-1:0] layer_alpha;
   logic                 first_layer;
   logic                 last_layer;

   modport source (
      output valid, channel_zero, channel_one, channel_two, layer_alpha,
             first_layer, last_layer,
      input  ready
   );
   modport sink (
      input  valid, channel_zero, channel_one, channel_two, layer_alpha,
             first_layer, last_layer,
      output ready
   );
endinterface

FILE: sv/lac_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Layer alpha compositor response channel
// Valid/ready channel carrying one composed pixel per last-layer request.
// ---------------------------------------------------------------------------
interface lac_rsp_if import lac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [LAC_PIX_W-1:0] out_channel_zero;
   logic [LAC_PIX_W-1:0] out_channel_one;
   logic [LAC_PIX_W-1:0] out_channel_two;
   logic [LAC_PIX_W-1:0] out_alpha;

   modport source (
      output valid, out_channel_zero, out_channel_one, out_channel_two, out_alpha,
      input  ready
   );
   modport sink (
      input  valid, out_channel_zero, out_channel_one, out_channel_two, out_alpha,
      output ready
   );
endinterface

FILE: sv/layer_alpha_compositor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Layer alpha compositor
// Porter-Duff "over" compositing of the layers of one pixel, top layer first.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Carries
//   req_chan  in         valid/ready        one layer pixel, first/last marks
//   rsp_chan  out        valid/ready        one composed pixel per last layer
//   csr_*     in         write enable only  pixel format (2 bits)
//
// A merging request runs from acceptance to the next ready through the accept,
// multiply and numerator/denominator states, the divide states of the restoring
// dividers (one quotient bit per step) and the write-back state. A request that
// needs no merge (copy or reserved format, or an opaque running pixel) leaves the
// block idle. A last-layer request then loads the response in the emit state once
// the response register is free. Reset is synchronous and active high; it clears
// the running pixel and sets the format to RGBA. A stalled response holds its data;
// requests keep flowing behind it until the next last-layer request reaches emit.
// ---------------------------------------------------------------------------
module layer_alpha_compositor import lac_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   lac_req_if.sink              req_chan,
   lac_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [LAC_FMT_W-1:0] csr_wr_data
);

   // Command and status between the sequencer and the arithmetic.
   lac_cmd_type  cmd;
   lac_stat_type stat;

   // The controller owns both handshakes and the step count of the divide.
   lac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the running pixel, the format register and the
   // response register, so the response payload comes straight from flops.
   lac_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_channel_zero (req_chan.channel_zero),
      .req_channel_one  (req_chan.channel_one),
      .req_channel_two  (req_chan.channel_two),
      .req_layer_alpha  (req_chan.layer_alpha),
      .req_first_layer  (req_chan.first_layer),
      .req_last_layer   (req_chan.last_layer),
      .rsp_channel_zero (rsp_chan.out_channel_zero),
      .rsp_channel_one  (rsp_chan.out_channel_one),
      .rsp_channel_two  (rsp_chan.out_channel_two),
      .rsp_alpha        (rsp_chan.out_alpha)
   );

endmodule

FILE: sv/lac_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Layer alpha compositor divider
// Restoring divider, one quotient bit per step, eight-bit quotient.
// ---------------------------------------------------------------------------
module lac_div import lac_pkg::*; (
   input  logic                 clock,
   input  logic                 load,
   input  logic                 step,
   input  logic [LAC_NUM_W-1:0] num,
   input  logic [LAC_DEN_W-1:0] den,
   output logic [LAC_PIX_W-1:0] quo
);

   logic [LAC_NUM_W-1:0] rem_ff, rem_in;
   logic [LAC_NUM_W-1:0] dsh_ff, dsh_in;
   logic [LAC_PIX_W-1:0] quo_ff, quo_in;
   logic                 fits;

   // The quotient is known to stay below 256, so the divisor starts
   // aligned to the top quotient bit.
   always_comb begin
      fits   = (rem_ff >= dsh_ff);
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (load) begin
         rem_in = num;
         dsh_in = {1'b0, den, 7'b0};
         quo_in = '0;
      end else if (step) begin
         rem_in = fits ? (rem_ff - dsh_ff) : rem_ff;
         dsh_in = {1'b0, dsh_ff[LAC_NUM_W-1:1]};
         quo_in = {quo_ff[LAC_PIX_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

FILE: sv/lac_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Layer alpha compositor datapath
// Running pixel, format register, products, three dividers and result register.
// ---------------------------------------------------------------------------
module lac_datapath import lac_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  lac_cmd_type          cmd,
   output lac_stat_type         stat,
   input  logic                 csr_wr_en,
   input  logic [LAC_FMT_W-1:0] csr_wr_data,
   input  logic [LAC_PIX_W-1:0] req_channel_zero,
   input  logic [LAC_PIX_W-1:0] req_channel_one,
   input  logic [LAC_PIX_W-1:0] req_channel_two,
   input  logic [LAC_PIX_W-1:0] req_layer_alpha,
   input  logic                 req_first_layer,
   input  logic                 req_last_layer,
   output logic [LAC_PIX_W-1:0] rsp_channel_zero,
   output logic [LAC_PIX_W-1:0] rsp_channel_one,
   output logic [LAC_PIX_W-1:0] rsp_channel_two,
   output logic [LAC_PIX_W-1:0] rsp_alpha
);

   logic [LAC_FMT_W-1:0]  fmt_ff, fmt_in;
   logic [LAC_PIX_W-1:0]  run_color_ff [LAC_NCH];
   logic [LAC_PIX_W-1:0]  run_color_in [LAC_NCH];
   logic [LAC_PIX_W-1:0]  run_alpha_ff, run_alpha_in;
   logic [LAC_PIX_W-1:0]  lay_color_ff [LAC_NCH];
   logic [LAC_PIX_W-1:0]  lay_alpha_ff;
   logic                  last_ff;
   logic [LAC_PROD_W-1:0] pa_ff [LAC_NCH];
   logic [LAC_PROD_W-1:0] pb_ff [LAC_NCH];
   logic [LAC_PROD_W-1:0] pp_ff;
   logic [LAC_PIX_W-1:0]  alpha_new_ff;
   logic                  den_zero_ff;
   logic [LAC_PIX_W-1:0]  out_ff [4];
   logic [LAC_PIX_W-1:0]  req_color [LAC_NCH];
   logic [LAC_NUM_W-1:0]  num [LAC_NCH];
   logic [LAC_DEN_W-1:0]  den;
   logic [16:0]           den_wide;
   logic [LAC_PROD_W-1:0] div255_sum;
   logic [8:0]            alpha_sum;
   logic [LAC_PIX_W-1:0]  inv_p1;
   logic [LAC_PIX_W-1:0]  quo [LAC_NCH];
   logic                  copy_mode;
   logic                  gray_mode;

   assign copy_mode = (fmt_ff inside {LAC_FMT_COPY, LAC_FMT_RSVD});
   assign gray_mode = (fmt_ff == LAC_FMT_GRAY);

   assign req_color[0] = req_channel_zero;
   assign req_color[1] = req_channel_one;
   assign req_color[2] = req_channel_two;

   // A cleared pixel is never opaque, so outside the copy and reserved formats only a continuing layer can skip.
   assign stat.skip_merge = copy_mode || (!req_first_layer && run_alpha_ff == LAC_OPAQUE);
   assign stat.req_last   = req_last_layer;
   assign stat.item_last  = last_ff;

   assign fmt_in = csr_wr_en ? csr_wr_data : fmt_ff;

   // Second multiply stage: numerator and denominator of the weighted average.
   assign inv_p1   = ~run_alpha_ff;
   assign den_wide = 17'({run_alpha_ff, 8'b0}) - 17'(run_alpha_ff)
                   + 17'({lay_alpha_ff, 8'b0}) - 17'(lay_alpha_ff) - 17'(pp_ff);
   assign den      = den_wide[LAC_DEN_W-1:0];

   // Exact floor(v / 255) for v up to 255 * 255.
   assign div255_sum = pp_ff + 16'(pp_ff[15:8]) + 16'd1;
   assign alpha_sum  = 9'(run_alpha_ff) + 9'(lay_alpha_ff) - 9'(div255_sum[15:8]);

   for (genvar k = 0; k < LAC_NCH; k++) begin : g_lane
      assign num[k] = 24'({pa_ff[k], 8'b0}) - 24'(pa_ff[k]) + 24'(inv_p1) * 24'(pb_ff[k]);

      lac_div u_div (
         .clock (clock),
         .load  (cmd.div_load),
         .step  (cmd.div_step),
         .num   (num[k]),
         .den   (den),
         .quo   (quo[k])
      );
   end

   always_comb begin
      for (int k = 0; k < LAC_NCH; k++) begin
         run_color_in[k] = run_color_ff[k];
      end
      run_alpha_in = run_alpha_ff;
      if (cmd.accept && req_first_layer) begin
         for (int k = 0; k < LAC_NCH; k++) begin
            run_color_in[k] = copy_mode ? req_color[k] : '0;
         end
         run_alpha_in = copy_mode ? req_layer_alpha : '0;
      end else if (cmd.write_back) begin
         for (int k = 0; k < LAC_NCH; k++) begin
            if (k == 0 || !gray_mode) begin
               run_color_in[k] = den_zero_ff ? '0 : quo[k];
            end
         end
         run_alpha_in = alpha_new_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= LAC_FMT_RGBA;
         run_alpha_ff <= '0;
         for (int k = 0; k < LAC_NCH; k++) begin
            run_color_ff[k] <= '0;
         end
      end else begin
         fmt_ff       <= fmt_in;
         run_alpha_ff <= run_alpha_in;
         for (int k = 0; k < LAC_NCH; k++) begin
            run_color_ff[k] <= run_color_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         for (int k = 0; k < LAC_NCH; k++) begin
            lay_color_ff[k] <= req_color[k];
         end
         lay_alpha_ff <= req_layer_alpha;
         last_ff      <= req_last_layer;
      end
      if (cmd.mul) begin
         for (int k = 0; k < LAC_NCH; k++) begin
            pa_ff[k] <= 16'(run_alpha_ff) * 16'(run_color_ff[k]);
            pb_ff[k] <= 16'(lay_alpha_ff) * 16'(lay_color_ff[k]);
         end
         pp_ff <= 16'(run_alpha_ff) * 16'(lay_alpha_ff);
      end
      if (cmd.div_load) begin
         alpha_new_ff <= alpha_sum[LAC_PIX_W-1:0];
         den_zero_ff  <= (den == '0);
      end
      if (cmd.emit) begin
         out_ff[0] <= run_color_ff[0];
         out_ff[1] <= gray_mode ? '0 : run_color_ff[1];
         out_ff[2] <= gray_mode ? '0 : run_color_ff[2];
         out_ff[3] <= run_alpha_ff;
      end
   end

   assign rsp_channel_zero = out_ff[0];
   assign rsp_channel_one  = out_ff[1];
   assign rsp_channel_two  = out_ff[2];
   assign rsp_alpha        = out_ff[3];

endmodule

FILE: sv/lac_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Layer alpha compositor controller
// Sequences accept, multiply, divide, write-back and response per request.
// ---------------------------------------------------------------------------
module lac_ctrl import lac_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  lac_stat_type stat,
   output lac_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_NUM   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   localparam logic [2:0] DIV_LAST = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!stat.skip_merge) begin
                  state_in = ST_MUL;
               end else if (stat.req_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_back = 1'b1;
            state_in       = stat.item_last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/lac_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Layer alpha compositor checker
// Port-level properties of the compositor, attached by bind.
// ---------------------------------------------------------------------------
`include "layer_alpha_compositor_defines.svh"

module lac_checker import lac_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [LAC_PIX_W-1:0] rsp_channel_zero,
   input logic [LAC_PIX_W-1:0] rsp_channel_one,
   input logic [LAC_PIX_W-1:0] rsp_channel_two,
   input logic [LAC_PIX_W-1:0] rsp_alpha
);

   // Coming out of reset the block is empty and ready for a request.
   `LAC_ASSERT_RESET(a_reset_empty, reset, !rsp_valid && req_ready, "not idle after reset")

   // A new response is loaded only from a cycle in which no request was taken.
   `LAC_ASSERT_NOW(a_rsp_after_work, $rose(rsp_valid), !$past(req_ready), "response without work")

   // A request is never taken in the cycle a response is being loaded.
   `LAC_ASSERT_NOW(a_no_overlap, req_valid && req_ready, !$rose(rsp_valid) || !$past(req_ready), "overlap")

   // A stalled response keeps its data.
   `LAC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_channel_zero) && $stable(rsp_channel_one) && $stable(rsp_channel_two) && $stable(rsp_alpha), "response changed while stalled")

endmodule

bind layer_alpha_compositor lac_checker u_lac_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_channel_zero (rsp_chan.out_channel_zero),
   .rsp_channel_one  (rsp_chan.out_channel_one),
   .rsp_channel_two  (rsp_chan.out_channel_two),
   .rsp_alpha        (rsp_chan.out_alpha)
);
